// ===== hw/rtl/haversine_distance_defines.svh =====
// Assertion macros shared by the haversine distance RTL.
`ifndef HAVERSINE_DISTANCE_DEFINES_SVH
`define HAVERSINE_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HVD_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HVD_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hvd_pkg.sv =====
// Types, constants and helper functions for the haversine distance pipeline.
package hvd_pkg;

	localparam int CORDIC_ITERATIONS_DEF = 24;
	localparam int CW = 36;
	localparam int SQRT_STEPS = 31;
	localparam int RW = 62;

	localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [CW-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;
	localparam logic [33:0] DEG2RAD_MUL = 34'd8048910509;
	localparam logic [30:0] DIST_SCALE  = 31'd1274200000;
	localparam logic [30:0] ONE_Q30     = 31'd1073741824;

	function automatic logic signed [CW-1:0] atan_q30(input int k);
		logic signed [CW-1:0] v;
		unique case (k)
			0: v = 36'sd843314857;
			1: v = 36'sd497837829;
			2: v = 36'sd263043837;
			3: v = 36'sd133525159;
			4: v = 36'sd67021687;
			5: v = 36'sd33543516;
			6: v = 36'sd16775851;
			7: v = 36'sd8388437;
			8: v = 36'sd4194283;
			9: v = 36'sd2097149;
			10: v = 36'sd1048576;
			default: v = (k <= 30) ? (CW'(1) << (30 - k)) : '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] mul_q30(input logic signed [31:0] p,
		input logic signed [31:0] q);
		logic signed [63:0] prod;
		prod = 64'(p) * 64'(q);
		return 32'((prod + 64'sd536870912) >>> 30);
	endfunction

endpackage

// ===== hw/rtl/hvd_cordic_cell.sv =====
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered outputs.
module hvd_cordic_cell import hvd_pkg::*; #(
	parameter int IDX = 0,
	parameter bit VECTORING = 1'b0
) (
	input  logic clk,
	input  logic en,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] z_in,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out,
	output logic signed [CW-1:0] z_out
);

	localparam logic signed [CW-1:0] ANGLE = atan_q30(IDX);

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic up;

	always_comb begin
		xs = x_in >>> IDX;
		ys = y_in >>> IDX;
		up = VECTORING ? y_in[CW-1] : !z_in[CW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (up) begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - ANGLE;
			end else begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + ANGLE;
			end
		end
	end

endmodule

// ===== hw/rtl/hvd_sqrt_cell.sv =====
// One digit step of a restoring square root, registered outputs.
module hvd_sqrt_cell import hvd_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [RW-1:0] v_in,
	input  logic [RW-1:0] r_in,
	output logic [RW-1:0] v_out,
	output logic [RW-1:0] r_out
);

	localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - IDX));

	logic [RW-1:0] trial;

	assign trial = r_in + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_in >= trial) begin
				v_out <= v_in - trial;
				r_out <= (r_in >> 1) + BIT;
			end else begin
				v_out <= v_in;
				r_out <= r_in >> 1;
			end
		end
	end

endmodule

// ===== hw/rtl/haversine_distance.sv =====
// Top level of the pipelined haversine great-circle distance unit.
//
//  channel | signals                     | content
//  in      | s_tvalid s_tready s_tdata   | two positions, 1e-7 degree units
//  out     | m_tvalid m_tready m_tdata   | distance in centimeters
//
// One item enters per cycle unless the pipeline stalls; each item passes the
// four CORDIC rotation rows, the two 31-cell square root rows and the vectoring
// CORDIC row to reach the output register. The whole pipeline stalls only when
// the output register is full, not taken, and the last stage holds an item.
// Reset clears only the valid bits; the data registers are not reset.
`include "haversine_distance_defines.svh"

module haversine_distance import hvd_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// first_latitude, first_longitude, second_latitude, second_longitude, zero pad
	input  logic [127:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// distance_cm, zero pad
	output logic [31:0] m_tdata
);

	localparam int N = CORDIC_ITERATIONS;
	localparam int DEPTH = 2 * N + 42;
	localparam int IDX_S9 = N + 8;
	localparam int IDX_S10 = N + 40;

	logic en;
	logic [DEPTH-1:0] vld_q;
	logic out_valid_q;
	logic [30:0] out_data_q;

	logic signed [31:0] raw [4];
	logic [31:0] mag [4];
	logic [63:0] prod_s1 [4];
	logic [3:0] neg_s1;
	logic signed [CW-1:0] rad_s2 [4];
	logic signed [CW-1:0] ang_s3 [4];
	logic signed [CW-1:0] red_t [4];
	logic signed [CW-1:0] fold_t [4];
	logic [3:0] fold_neg;
	logic signed [CW-1:0] zr_s4 [4];
	logic [3:0] neg_s4;
	logic [3:0] neg_dly [N];

	wire signed [CW-1:0] cx [4][N+1];
	wire signed [CW-1:0] cy [4][N+1];
	wire signed [CW-1:0] cz [4][N+1];

	logic signed [31:0] slat_s5, slon_s5, c1_s5, c2_s5;
	logic signed [31:0] plat_s6, plon_s6, c1_s6, c2_s6;
	logic signed [31:0] plat_s7, q_s7, c2_s7;
	logic signed [31:0] plat_s8, r_s8;
	logic signed [32:0] asum;
	logic [30:0] a_s9;

	wire [RW-1:0] sv [2][SQRT_STEPS+1];
	wire [RW-1:0] sr [2][SQRT_STEPS+1];
	logic [30:0] root_a_s10, root_b_s10;

	wire signed [CW-1:0] ax [N+1];
	wire signed [CW-1:0] ay [N+1];
	wire signed [CW-1:0] az [N+1];
	logic [31:0] zc;
	logic [63:0] prod_s11;
	logic [63:0] dsum;

	assign en = m_tready || !out_valid_q || !vld_q[DEPTH-1];
	assign s_tready = en;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
			end
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (en && vld_q[DEPTH-1]) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_comb begin
		raw[0] = {s_tdata[30], s_tdata[30:0]};
		raw[1] = s_tdata[62:31];
		raw[2] = {s_tdata[93], s_tdata[93:63]};
		raw[3] = s_tdata[125:94];
		for (int g = 0; g < 4; g++) begin
			mag[g] = raw[g][31] ? 32'(-raw[g]) : 32'(raw[g]);
		end
	end

	always_comb begin
		for (int g = 0; g < 4; g++) begin
			if (ang_s3[g] > PI_Q30) begin
				red_t[g] = ang_s3[g] - TWO_PI_Q30;
			end else if (ang_s3[g] < -PI_Q30) begin
				red_t[g] = ang_s3[g] + TWO_PI_Q30;
			end else begin
				red_t[g] = ang_s3[g];
			end
			if (red_t[g] > HALF_PI_Q30) begin
				fold_t[g] = red_t[g] - PI_Q30;
				fold_neg[g] = 1'b1;
			end else if (red_t[g] < -HALF_PI_Q30) begin
				fold_t[g] = red_t[g] + PI_Q30;
				fold_neg[g] = 1'b1;
			end else begin
				fold_t[g] = red_t[g];
				fold_neg[g] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < 4; g++) begin
				prod_s1[g] <= 64'(mag[g]) * 64'(DEG2RAD_MUL);
				neg_s1[g] <= raw[g][31];
				rad_s2[g] <= neg_s1[g] ? -$signed(CW'(prod_s1[g][63:32] + 32'(prod_s1[g][31])))
					: $signed(CW'(prod_s1[g][63:32] + 32'(prod_s1[g][31])));
				zr_s4[g] <= fold_t[g];
			end
			ang_s3[0] <= (rad_s2[2] - rad_s2[0]) >>> 1;
			ang_s3[1] <= (rad_s2[3] - rad_s2[1]) >>> 1;
			ang_s3[2] <= rad_s2[0];
			ang_s3[3] <= rad_s2[2];
			neg_s4 <= fold_neg;
			neg_dly[0] <= neg_s4;
			for (int k = 1; k < N; k++) begin
				neg_dly[k] <= neg_dly[k-1];
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_trig
		assign cx[g][0] = GAIN_Q30;
		assign cy[g][0] = '0;
		assign cz[g][0] = zr_s4[g];
		for (genvar k = 0; k < N; k++) begin : g_cell
			hvd_cordic_cell #(.IDX(k), .VECTORING(1'b0)) u_cell (
				.clk(clk),
				.en(en),
				.x_in(cx[g][k]),
				.y_in(cy[g][k]),
				.z_in(cz[g][k]),
				.x_out(cx[g][k+1]),
				.y_out(cy[g][k+1]),
				.z_out(cz[g][k+1])
			);
		end
	end

	always_comb begin
		asum = 33'(plat_s8) + 33'(r_s8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slat_s5 <= 32'(neg_dly[N-1][0] ? -cy[0][N] : cy[0][N]);
			slon_s5 <= 32'(neg_dly[N-1][1] ? -cy[1][N] : cy[1][N]);
			c1_s5 <= 32'(neg_dly[N-1][2] ? -cx[2][N] : cx[2][N]);
			c2_s5 <= 32'(neg_dly[N-1][3] ? -cx[3][N] : cx[3][N]);
			plat_s6 <= mul_q30(slat_s5, slat_s5);
			plon_s6 <= mul_q30(slon_s5, slon_s5);
			c1_s6 <= c1_s5;
			c2_s6 <= c2_s5;
			plat_s7 <= plat_s6;
			q_s7 <= mul_q30(plon_s6, c1_s6);
			c2_s7 <= c2_s6;
			plat_s8 <= plat_s7;
			r_s8 <= mul_q30(q_s7, c2_s7);
			if (asum < 33'sd0) begin
				a_s9 <= '0;
			end else if (asum > 33'sd1073741824) begin
				a_s9 <= ONE_Q30;
			end else begin
				a_s9 <= asum[30:0];
			end
		end
	end

	assign sv[0][0] = RW'({a_s9, 30'b0});
	assign sv[1][0] = RW'({31'(ONE_Q30 - a_s9), 30'b0});
	assign sr[0][0] = '0;
	assign sr[1][0] = '0;

	for (genvar h = 0; h < 2; h++) begin : g_root
		for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
			hvd_sqrt_cell #(.IDX(k)) u_cell (
				.clk(clk),
				.en(en),
				.v_in(sv[h][k]),
				.r_in(sr[h][k]),
				.v_out(sv[h][k+1]),
				.r_out(sr[h][k+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_a_s10 <= 31'(sr[0][SQRT_STEPS] + RW'(sv[0][SQRT_STEPS] > sr[0][SQRT_STEPS]));
			root_b_s10 <= 31'(sr[1][SQRT_STEPS] + RW'(sv[1][SQRT_STEPS] > sr[1][SQRT_STEPS]));
		end
	end

	assign ax[0] = $signed(CW'(root_b_s10));
	assign ay[0] = $signed(CW'(root_a_s10));
	assign az[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_atan
		hvd_cordic_cell #(.IDX(k), .VECTORING(1'b1)) u_cell (
			.clk(clk),
			.en(en),
			.x_in(ax[k]),
			.y_in(ay[k]),
			.z_in(az[k]),
			.x_out(ax[k+1]),
			.y_out(ay[k+1]),
			.z_out(az[k+1])
		);
	end

	always_comb begin
		zc = az[N][CW-1] ? 32'd0 : az[N][31:0];
		dsum = prod_s11 + 64'd536870912;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s11 <= 64'(zc) * 64'(DIST_SCALE);
		end
		if (en && vld_q[DEPTH-1]) begin
			out_data_q <= dsum[60:30];
		end
	end

	`HVD_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid_q, s_tready, "ready low with empty output register")
	`HVD_ASSERT_NXT(a_hold_on_stall, clk, arst_n, !s_tready, $stable(vld_q), "pipeline moved while stalled")
	`HVD_ASSERT_IMP(a_clamp_range, clk, arst_n, vld_q[IDX_S9], a_s9 <= ONE_Q30, "haversine term above one")
	`HVD_ASSERT_IMP(a_root_range, clk, arst_n, vld_q[IDX_S10], root_a_s10 <= ONE_Q30, "root above one")

endmodule

// ===== verif/tb_haversine_distance.sv =====
// Self-checking testbench for the haversine great-circle distance pipeline.
`timescale 1ns / 100ps

module tb_haversine_distance;
	import hvd_pkg::*;

	localparam int N_RANDOM = 630;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 2 * CORDIC_ITERATIONS_DEF + 60;
	localparam longint unsigned RAD_PER_UNIT = 64'd8048910509;
	localparam longint PI_FX = 64'sd3373259426;
	localparam longint HALF_PI_FX = 64'sd1686629713;
	localparam longint TWO_PI_FX = 64'sd6746518852;
	localparam longint UNIT_FX = 64'sd1073741824;
	localparam longint GAIN_FX = 64'sd652032874;
	localparam longint CM_PER_RAD_X2 = 64'sd1274200000;

	typedef struct {
		logic signed [30:0] lat1;
		logic signed [31:0] lon1;
		logic signed [30:0] lat2;
		logic signed [31:0] lon2;
		longint want_cm;
	} pair_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [127:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;

	logic [30:0] distance_fifo[$];
	int mismatches;
	int idle_cycles;
	int rx_hold;
	bit steady_flow;

	longint arctan_steps[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149, 1048576};

	haversine_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint arc_step(input int k);
		if (k < 11) begin
			return arctan_steps[k];
		end
		return (k <= 30) ? (64'sd1 <<< (30 - k)) : 64'sd0;
	endfunction

	function automatic longint units_to_rad(input longint x);
		longint unsigned mag;
		longint r;
		mag = (x < 0) ? longint'(-x) : longint'(x);
		r = longint'((mag * RAD_PER_UNIT + 64'h8000_0000) >> 32);
		return (x < 0) ? -r : r;
	endfunction

	function automatic longint fx_mul(input longint p, input longint q);
		return (p * q + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic void rotate_sin_cos(input longint t, output longint s,
		output longint c);
		longint x, y, z, nx;
		bit flip;
		x = GAIN_FX;
		y = 0;
		flip = 1'b0;
		t = t % TWO_PI_FX;
		if (t > PI_FX) t -= TWO_PI_FX;
		if (t < -PI_FX) t += TWO_PI_FX;
		if (t > HALF_PI_FX) begin
			t -= PI_FX;
			flip = 1'b1;
		end else if (t < -HALF_PI_FX) begin
			t += PI_FX;
			flip = 1'b1;
		end
		z = t;
		for (int i = 0; i < CORDIC_ITERATIONS_DEF && i < 32; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arc_step(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arc_step(i);
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint isqrt_round(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (v > r) r++;
		return longint'(r);
	endfunction

	function automatic longint vector_angle(input longint y, input longint x);
		longint z, nx;
		z = 0;
		for (int i = 0; i < CORDIC_ITERATIONS_DEF && i < 32; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arc_step(i);
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arc_step(i);
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic logic [30:0] great_circle_cm(input logic signed [30:0] lat1_u,
		input logic signed [31:0] lon1_u, input logic signed [30:0] lat2_u,
		input logic signed [31:0] lon2_u);
		longint lat1, lon1, lat2, lon2, s_lat, s_lon, c1, c2, dummy, hav, z;
		longint unsigned cm;
		lat1 = units_to_rad(longint'(lat1_u));
		lon1 = units_to_rad(longint'(lon1_u));
		lat2 = units_to_rad(longint'(lat2_u));
		lon2 = units_to_rad(longint'(lon2_u));
		rotate_sin_cos((lat2 - lat1) >>> 1, s_lat, dummy);
		rotate_sin_cos((lon2 - lon1) >>> 1, s_lon, dummy);
		rotate_sin_cos(lat1, dummy, c1);
		rotate_sin_cos(lat2, dummy, c2);
		hav = fx_mul(s_lat, s_lat) + fx_mul(fx_mul(fx_mul(s_lon, s_lon), c1), c2);
		if (hav < 0) hav = 0;
		if (hav > UNIT_FX) hav = UNIT_FX;
		z = vector_angle(isqrt_round(longint'(hav) << 30),
			isqrt_round(longint'(UNIT_FX - hav) << 30));
		if (z < 0) z = 0;
		cm = (longint'(CM_PER_RAD_X2) * z + (64'sd1 <<< 29)) >> 30;
		return cm[30:0];
	endfunction

	task automatic send_pair(input pair_row_t row);
		int gap;
		bit done;
		gap = steady_flow ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {2'b00, row.lon2, row.lat2, row.lon1, row.lat1};
		s_tvalid <= 1'b1;
		done = 1'b0;
		while (!done) begin
			@(posedge clk);
			done = s_tready;
		end
		if (row.want_cm >= 0) begin
			distance_fifo.push_back(row.want_cm[30:0]);
		end else begin
			distance_fifo.push_back(great_circle_cm(row.lat1, row.lon1, row.lat2, row.lon2));
		end
	endtask

	function automatic pair_row_t random_pair(input bit raw);
		pair_row_t r;
		if (raw) begin
			r.lat1 = 31'($urandom);
			r.lon1 = $urandom;
			r.lat2 = 31'($urandom);
			r.lon2 = $urandom;
		end else begin
			r.lat1 = 31'(int'($urandom_range(0, 1800000000)) - 900000000);
			r.lon1 = int'($urandom_range(0, 3600000000)) - 1800000000;
			r.lat2 = 31'(int'($urandom_range(0, 1800000000)) - 900000000);
			r.lon2 = int'($urandom_range(0, 3600000000)) - 1800000000;
			if ($urandom_range(0, 3) == 0) begin
				r.lat2 = 31'(int'(r.lat1) + int'($urandom_range(0, 2000)) - 1000);
				r.lon2 = r.lon1 + int'($urandom_range(0, 2000)) - 1000;
			end
		end
		r.want_cm = -1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold <= 0;
		end else begin
			int hold;
			hold = rx_hold;
			if (m_tvalid && m_tready) begin
				if (distance_fifo.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected distance item: %0d", m_tdata[30:0]);
				end else begin
					logic [30:0] want;
					want = distance_fifo.pop_front();
					if (m_tdata[30:0] !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("distance_cm mismatch: expected %0d, got %0d",
								want, m_tdata[30:0]);
					end
				end
				hold = steady_flow ? 0 : $urandom_range(0, 3);
			end else if (hold > 0) begin
				hold--;
			end
			rx_hold <= hold;
			m_tready <= (hold == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_haversine_distance: errors");
				$finish;
			end
		end
	end

	initial begin
		pair_row_t directed[$];
		directed = '{
			'{31'sd0, 32'sd0, 31'sd0, 32'sd0, -1},
			'{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0, -1},
			'{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000, -1},
			'{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000, -1},
			'{31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000, -1},
			'{-31'sd900000000, -32'sd1800000000, 31'sd0, 32'sd900000000, -1},
			'{31'sd450000000, 32'sd123456789, 31'sd450000000, 32'sd123456789, -1},
			'{31'sd0, 32'sd0, 31'sd1, 32'sd1, -1},
			'{31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000, 32'h8000_0000, -1},
			'{31'h4000_0000, 32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF, -1},
			'{31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, -1},
			'{31'h5555_5555, 32'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA, -1},
			'{31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555, 32'h5555_5555, -1},
			'{31'sd515000000, -32'sd1000000, 31'sd488500000, 32'sd23500000, -1},
			'{-31'sd338000000, 32'sd1512000000, 31'sd407000000, -32'sd740000000, -1}
		};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		steady_flow = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_pair(directed[i]);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 300) begin
				s_tvalid <= 1'b0;
				wait (distance_fifo.size() == 0);
				@(posedge clk);
			end
			steady_flow = (n >= 150 && n < 230);
			send_pair(random_pair($urandom_range(0, 9) == 0));
		end
		s_tvalid <= 1'b0;
		steady_flow = 1'b0;
		wait (distance_fifo.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && distance_fifo.size() == 0) begin
			$display("tb_haversine_distance: clean");
		end else begin
			$display("tb_haversine_distance: errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/hvd_pkg.sv
hw/rtl/hvd_cordic_cell.sv
hw/rtl/hvd_sqrt_cell.sv
hw/rtl/haversine_distance.sv
verif/tb_haversine_distance.sv
